[rtl/tts_pkg.sv]
// Shared types and constants for the transposition table store unit.
// Used by tts_ram, transposition_table_store_unit and the verification files; depends on nothing.
package tts_pkg;

	localparam int unsigned TABLE_ENTRIES_DEFAULT = 4096;
	localparam int unsigned HASH_W = 64;
	localparam logic [6:0] NULL_SQUARE = 7'd127;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_STORE   = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_PROTECT = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [63:0]        tag;
		logic [7:0]         depth;
		logic signed [15:0] score;
		logic [1:0]         bound;
		logic [6:0]         from_sq;
		logic [6:0]         to_sq;
	} entry_t;

	localparam entry_t MISS_ENTRY = '{
		tag: 64'd0,
		depth: 8'd0,
		score: 16'sd0,
		bound: 2'd0,
		from_sq: NULL_SQUARE,
		to_sq: NULL_SQUARE
	};

endpackage

[rtl/tts_ram.sv]
// Single-port-write, single-port-read synchronous entry memory with registered read data.
// Depends on tts_pkg for the entry type.
module tts_ram #(
	parameter int unsigned DEPTH = tts_pkg::TABLE_ENTRIES_DEFAULT,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_W-1:0]     waddr,
	input  tts_pkg::entry_t       wdata,
	input  logic                  re,
	input  logic [ADDR_W-1:0]     raddr,
	output tts_pkg::entry_t       rdata
);

	tts_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/transposition_table_store_unit.sv]
// Top level of the transposition table store: request control, replacement rules, result register.
// Depends on tts_pkg and tts_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------------
//  request | in        | in_valid/in_ready   | opcode, key_hash, entry_depth, entry_score,
//          |           |                    | entry_bound, move_from, move_to
//  result  | out       | out_valid/out_ready | hit, written, found_hash, found_depth,
//          |           |                    | found_score, found_bound, found_from, found_to
//
// Lookup, store and protect read the slot, then compare and write back.
// With a TABLE_ENTRIES that is not a power of two, the slot index is first formed as a
// remainder (byte fold against constant weights, reciprocal multiply, subtract and correct).
// Clear sweeps one entry per cycle, then gives its reply.
// After reset the same sweep runs with in_ready low and gives no reply.
// A result waiting on out_ready holds the next request in its compare cycle.
module transposition_table_store_unit #(
	parameter int unsigned TABLE_ENTRIES = tts_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [63:0]        key_hash,
	input  logic [7:0]         entry_depth,
	input  logic signed [15:0] entry_score,
	input  logic [1:0]         entry_bound,
	input  logic [6:0]         move_from,
	input  logic [6:0]         move_to,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic               written,
	output logic [63:0]        found_hash,
	output logic [7:0]         found_depth,
	output logic signed [15:0] found_score,
	output logic [1:0]         found_bound,
	output logic [6:0]         found_from,
	output logic [6:0]         found_to
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << IDX_W));
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0] ENTRIES_W = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [1:0] REDUCE_LAST = 2'd2;

	// 2^(8*pos) mod TABLE_ENTRIES by repeated doubling
	function automatic logic [IDX_W-1:0] byte_weight(input int unsigned pos);
		logic [IDX_W:0] w;
		w = (IDX_W + 1)'(1);
		for (int unsigned b = 0; b < 8 * pos; b++) begin
			w = {w[IDX_W-1:0], 1'b0};
			if (w >= ENTRIES_W) begin
				w = w - ENTRIES_W;
			end
		end
		return w[IDX_W-1:0];
	endfunction

	localparam logic [IDX_W-1:0] BYTE_WEIGHT [8] = '{
		byte_weight(0), byte_weight(1), byte_weight(2), byte_weight(3),
		byte_weight(4), byte_weight(5), byte_weight(6), byte_weight(7)
	};
	localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(TABLE_ENTRIES));

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_REDUCE,
		ST_EVAL,
		ST_REPLY
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  sweep_q;
	logic              reply_q;
	logic [63:0]       prot_q;

	tts_pkg::opcode_t  op_q;
	tts_pkg::entry_t   req_q;
	logic [IDX_W-1:0]  addr_q;
	logic [30:0]       fold_q;
	logic [30:0]       quot_q;
	logic [1:0]        step_q;

	logic              accept;
	logic              slot_free;
	logic              eval_fire;
	logic              reply_fire;
	tts_pkg::opcode_t  in_op;
	logic [30:0]       fold_sum;
	logic [61:0]       quot_prod;
	logic [30:0]       rem_wide;
	logic [IDX_W-1:0]  rem_next;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	tts_pkg::entry_t   mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	tts_pkg::entry_t   cur;

	logic              tag_eq;
	logic              replace;
	logic              plant;
	logic              res_hit;
	logic              res_written;
	tts_pkg::entry_t   res_entry;
	tts_pkg::entry_t   planted;

	tts_ram #(
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (cur)
	);

	assign in_op      = tts_pkg::opcode_t'(opcode);
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid || out_ready;
	assign eval_fire  = (state_q == ST_EVAL) && slot_free;
	assign reply_fire = (state_q == ST_REPLY) && slot_free;

	// fold the hash bytes against their weights: congruent to the hash, below 2^31
	always_comb begin
		fold_sum = '0;
		for (int i = 0; i < 8; i++) begin
			fold_sum = fold_sum + 31'(req_q.tag[8*i +: 8] * BYTE_WEIGHT[i]);
		end
	end

	// quotient estimate is exact or one short, so one correction finishes the remainder
	assign quot_prod = 62'(fold_q) * 62'(RECIP);

	always_comb begin
		rem_wide = fold_q - 31'(quot_q * 31'(TABLE_ENTRIES));
		if (rem_wide >= 31'(TABLE_ENTRIES)) begin
			rem_wide = rem_wide - 31'(TABLE_ENTRIES);
		end
		rem_next = rem_wide[IDX_W-1:0];
	end

	assign tag_eq  = (cur.tag == req_q.tag);
	assign replace = ((cur.tag != prot_q) && !tag_eq) || (tag_eq && (cur.depth <= req_q.depth));
	assign plant   = !tag_eq;

	always_comb begin
		planted         = tts_pkg::MISS_ENTRY;
		planted.tag     = req_q.tag;
		planted.bound   = cur.bound;
	end

	always_comb begin
		res_written = 1'b0;
		case (op_q)
			tts_pkg::OP_STORE:   res_written = replace;
			tts_pkg::OP_PROTECT: res_written = plant;
			default:             res_written = 1'b0;
		endcase
		res_hit   = (op_q == tts_pkg::OP_LOOKUP) && tag_eq;
		res_entry = res_hit ? cur : tts_pkg::MISS_ENTRY;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = req_q;
		if (state_q == ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else if (eval_fire && res_written) begin
			mem_we    = 1'b1;
			mem_wdata = (op_q == tts_pkg::OP_PROTECT) ? planted : req_q;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = key_hash[IDX_W-1:0];
		if (accept && IS_POW2 && (in_op != tts_pkg::OP_CLEAR)) begin
			mem_re = 1'b1;
		end else if ((state_q == ST_REDUCE) && (step_q == REDUCE_LAST)) begin
			mem_re    = 1'b1;
			mem_raddr = rem_next;
		end
	end

	// state, sweep index, protected key and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			sweep_q   <= '0;
			reply_q   <= 1'b0;
			prot_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (eval_fire || reply_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (eval_fire && (op_q == tts_pkg::OP_PROTECT)) begin
				prot_q <= req_q.tag;
			end
			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_q == LAST_IDX) begin
						sweep_q <= '0;
						state_q <= reply_q ? ST_REPLY : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_op == tts_pkg::OP_CLEAR) begin
							reply_q <= 1'b1;
							state_q <= ST_SWEEP;
						end else if (IS_POW2) begin
							state_q <= ST_EVAL;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (step_q == REDUCE_LAST) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REPLY: begin
					if (slot_free) begin
						reply_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request, remainder steps and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= in_op;
			req_q.tag     <= key_hash;
			req_q.depth   <= entry_depth;
			req_q.score   <= entry_score;
			req_q.bound   <= entry_bound;
			req_q.from_sq <= move_from;
			req_q.to_sq   <= move_to;
			addr_q        <= key_hash[IDX_W-1:0];
			step_q        <= '0;
		end else if (state_q == ST_REDUCE) begin
			fold_q <= fold_sum;
			quot_q <= quot_prod[61:31];
			step_q <= step_q + 1'b1;
			if (step_q == REDUCE_LAST) begin
				addr_q <= rem_next;
			end
		end
		if (eval_fire) begin
			hit         <= res_hit;
			written     <= res_written;
			found_hash  <= res_entry.tag;
			found_depth <= res_entry.depth;
			found_score <= res_entry.score;
			found_bound <= res_entry.bound;
			found_from  <= res_entry.from_sq;
			found_to    <= res_entry.to_sq;
		end else if (reply_fire) begin
			hit         <= 1'b0;
			written     <= 1'b0;
			found_hash  <= tts_pkg::MISS_ENTRY.tag;
			found_depth <= tts_pkg::MISS_ENTRY.depth;
			found_score <= tts_pkg::MISS_ENTRY.score;
			found_bound <= tts_pkg::MISS_ENTRY.bound;
			found_from  <= tts_pkg::MISS_ENTRY.from_sq;
			found_to    <= tts_pkg::MISS_ENTRY.to_sq;
		end
	end

	a_sweep_blocks_requests: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !in_ready)
		else $error("request taken during table sweep");

	a_sweep_index_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (sweep_q == '0))
		else $error("sweep index not parked outside a sweep");

	a_eval_produces_result: assert property (@(posedge clk) disable iff (!arst_n)
		eval_fire |=> (out_valid && (state_q == ST_IDLE)))
		else $error("evaluated request did not yield a result");

	a_write_only_on_eval_or_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_SWEEP) || eval_fire))
		else $error("table written outside sweep or evaluation");

	a_hit_never_written: assert property (@(posedge clk) disable iff (!arst_n)
		(eval_fire && res_hit) |=> !written)
		else $error("lookup hit flagged as a write");

endmodule

[verif/tts_result_checker.sv]
// Reply checker for the transposition table store unit: keeps its own copy of the table,
// predicts one reply per accepted request and compares replies in order.
// Depends on tts_pkg for the opcode and entry types.
module tts_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [63:0]        key_hash,
	input  logic [7:0]         entry_depth,
	input  logic signed [15:0] entry_score,
	input  logic [1:0]         entry_bound,
	input  logic [6:0]         move_from,
	input  logic [6:0]         move_to,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               hit,
	input  logic               written,
	input  logic [63:0]        found_hash,
	input  logic [7:0]         found_depth,
	input  logic signed [15:0] found_score,
	input  logic [1:0]         found_bound,
	input  logic [6:0]         found_from,
	input  logic [6:0]         found_to,
	output int                 mismatches,
	output int                 replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = tts_pkg::TABLE_ENTRIES_DEFAULT;
	localparam int MAX_SHOWN = 50;

	typedef struct packed {
		logic            hit;
		logic            written;
		tts_pkg::entry_t ent;
	} reply_t;

	tts_pkg::entry_t slot_model [SLOTS];
	logic [63:0]     guarded_key;
	reply_t          awaited_replies [$];
	int              shown = 0;

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (shown < MAX_SHOWN)
			$display("[%0t] reply %s: got %0h, want %0h", $time, field, got, want);
		shown++;
		mismatches = mismatches + 1;
	endtask

	// Apply one request to the table copy and return the reply it must produce.
	function automatic reply_t apply_table_op(input tts_pkg::opcode_t op,
			input logic [63:0] key,
			input logic [7:0] depth, input logic signed [15:0] score,
			input logic [1:0] bound, input logic [6:0] src_sq, input logic [6:0] dst_sq);
		reply_t          r;
		tts_pkg::entry_t cur;
		int unsigned     idx;
		logic            accept;
		idx = int'(key % 64'(SLOTS));
		cur = slot_model[idx];
		r.hit = 1'b0;
		r.written = 1'b0;
		r.ent = tts_pkg::MISS_ENTRY;
		case (op)
			tts_pkg::OP_LOOKUP: begin
				if (cur.tag == key) begin
					r.hit = 1'b1;
					r.ent = cur;
				end
			end
			tts_pkg::OP_STORE: begin
				accept = (cur.tag != guarded_key && cur.tag != key) ||
					(cur.tag == key && cur.depth <= depth);
				if (accept)
					slot_model[idx] = '{tag: key, depth: depth, score: score, bound: bound,
						from_sq: src_sq, to_sq: dst_sq};
				r.written = accept;
			end
			tts_pkg::OP_CLEAR: begin
				foreach (slot_model[i])
					slot_model[i] = '0;
			end
			tts_pkg::OP_PROTECT: begin
				guarded_key = key;
				// plant keeps the old bound of the slot
				if (cur.tag != key) begin
					cur.tag = key;
					cur.depth = '0;
					cur.score = '0;
					cur.from_sq = tts_pkg::NULL_SQUARE;
					cur.to_sq = tts_pkg::NULL_SQUARE;
					slot_model[idx] = cur;
					r.written = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			foreach (slot_model[i])
				slot_model[i] = '0;
			guarded_key = '0;
			awaited_replies.delete();
			replies_due = 0;
		end else begin
			// retire before predicting: a reply never belongs to a request of the same edge
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch("with no request", found_hash, '0);
				end else begin
					want = awaited_replies.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", hit, want.hit);
					if (written !== want.written)
						report_mismatch("written", written, want.written);
					if (found_hash !== want.ent.tag)
						report_mismatch("found_hash", found_hash, want.ent.tag);
					if (found_depth !== want.ent.depth)
						report_mismatch("found_depth", found_depth, want.ent.depth);
					if (found_score !== want.ent.score)
						report_mismatch("found_score", found_score, want.ent.score);
					if (found_bound !== want.ent.bound)
						report_mismatch("found_bound", found_bound, want.ent.bound);
					if (found_from !== want.ent.from_sq)
						report_mismatch("found_from", found_from, want.ent.from_sq);
					if (found_to !== want.ent.to_sq)
						report_mismatch("found_to", found_to, want.ent.to_sq);
				end
			end
			if (in_valid && in_ready)
				awaited_replies.push_back(apply_table_op(tts_pkg::opcode_t'(opcode),
					key_hash, entry_depth, entry_score, entry_bound, move_from, move_to));
			replies_due = awaited_replies.size();
		end
	end

endmodule

[verif/tb_transposition_table_store_unit.sv]
// Testbench top for transposition_table_store_unit: clock, reset, request and reply-side
// stimulus, watchdog and verdict. Depends on tts_pkg, that module and tts_result_checker.
module tb_transposition_table_store_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int IDLE_PERCENT = 12;

	localparam logic [1:0] BOUND_EXACT = 2'd0;
	localparam logic [1:0] BOUND_LOWER = 2'd1;
	localparam logic [1:0] BOUND_UPPER = 2'd2;
	localparam logic [1:0] BOUND_SPARE = 2'd3;

	localparam logic [63:0] KEY_A = 64'hFFFF_FFFF_FFFF_F005;
	localparam logic [63:0] KEY_B = 64'h0123_4567_89AB_C005;
	localparam logic [63:0] KEY_C = 64'h8000_0000_0000_0007;
	localparam logic [63:0] KEY_D = 64'h5555_AAAA_5555_A005;
	localparam logic [63:0] KEY_ONES = '1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic [63:0]        key_hash;
	logic [7:0]         entry_depth;
	logic signed [15:0] entry_score;
	logic [1:0]         entry_bound;
	logic [6:0]         move_from;
	logic [6:0]         move_to;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic               written;
	logic [63:0]        found_hash;
	logic [7:0]         found_depth;
	logic signed [15:0] found_score;
	logic [1:0]         found_bound;
	logic [6:0]         found_from;
	logic [6:0]         found_to;

	int          mismatches;
	int          replies_due;
	int          quiet_cycles = 0;
	logic        calm;
	logic [51:0] tag_pool [6];
	logic [11:0] slot_pool [4];

	transposition_table_store_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key_hash(key_hash), .entry_depth(entry_depth),
		.entry_score(entry_score), .entry_bound(entry_bound),
		.move_from(move_from), .move_to(move_to),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .written(written), .found_hash(found_hash), .found_depth(found_depth),
		.found_score(found_score), .found_bound(found_bound),
		.found_from(found_from), .found_to(found_to)
	);

	tts_result_checker reply_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key_hash(key_hash), .entry_depth(entry_depth),
		.entry_score(entry_score), .entry_bound(entry_bound),
		.move_from(move_from), .move_to(move_to),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .written(written), .found_hash(found_hash), .found_depth(found_depth),
		.found_score(found_score), .found_bound(found_bound),
		.found_from(found_from), .found_to(found_to),
		.mismatches(mismatches), .replies_due(replies_due)
	);

	always #6 clk = ~clk;

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

	// a clear or the reset sweep stalls for a whole table pass; a quiet stretch past WATCHDOG_LIMIT is a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input tts_pkg::opcode_t op, input logic [63:0] key,
			input logic [7:0] depth, input logic signed [15:0] score,
			input logic [1:0] bound, input logic [6:0] src_sq, input logic [6:0] dst_sq);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		opcode <= op;
		key_hash <= key;
		entry_depth <= depth;
		entry_score <= score;
		entry_bound <= bound;
		move_from <= src_sq;
		move_to <= dst_sq;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Mostly keys from a few slots and tags, so hits, refusals and depth races are common.
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return {tag_pool[$urandom_range(0, 5)], slot_pool[$urandom_range(0, 3)]};
		else if (r < 83)
			return '0;
		else
			return {$urandom, $urandom};
	endfunction

	task automatic send_random_request();
		int               r;
		tts_pkg::opcode_t op;
		r = $urandom_range(0, 199);
		if (r < 70)
			op = tts_pkg::OP_LOOKUP;
		else if (r < 160)
			op = tts_pkg::OP_STORE;
		else if (r < 198)
			op = tts_pkg::OP_PROTECT;
		else
			op = tts_pkg::OP_CLEAR;
		send_request(op, pick_key(),
			$urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)),
			16'($urandom), 2'($urandom_range(0, 3)),
			7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= tts_pkg::OP_LOOKUP;
		key_hash <= '0;
		entry_depth <= '0;
		entry_score <= '0;
		entry_bound <= BOUND_EXACT;
		move_from <= '0;
		move_to <= '0;
		out_ready <= 1'b0;
		calm <= 1'b0;
		foreach (tag_pool[i])
			tag_pool[i] = 52'({$urandom, $urandom});
		slot_pool[0] = 12'h000;
		slot_pool[1] = 12'hFFF;
		slot_pool[2] = 12'($urandom);
		slot_pool[3] = 12'($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// cleared slot holds tag 0 with squares 0, and the protected key starts at 0
		send_request(tts_pkg::OP_LOOKUP, '0, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_STORE, KEY_A, 8'd3, 16'sd5, BOUND_LOWER, 7'd1, 7'd2);
		send_request(tts_pkg::OP_PROTECT, KEY_A, 8'd9, 16'sd9, BOUND_UPPER, 7'd9, 7'd9);
		send_request(tts_pkg::OP_LOOKUP, KEY_A, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_PROTECT, KEY_A, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_STORE, KEY_B, 8'd255, 16'sd1, BOUND_EXACT, 7'd3, 7'd4);
		send_request(tts_pkg::OP_STORE, KEY_A, 8'd10, 16'sh8000, BOUND_SPARE, 7'd0, 7'd127);
		send_request(tts_pkg::OP_STORE, KEY_A, 8'd9, 16'sd7, BOUND_LOWER, 7'd5, 7'd6);
		send_request(tts_pkg::OP_STORE, KEY_A, 8'd10, 16'sd32767, BOUND_UPPER, 7'd127, 7'd0);
		send_request(tts_pkg::OP_LOOKUP, KEY_A, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_LOOKUP, KEY_B, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_PROTECT, KEY_C, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_STORE, KEY_B, 8'd0, -16'sd1, BOUND_LOWER, 7'd64, 7'd63);
		send_request(tts_pkg::OP_LOOKUP, KEY_B, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_STORE, KEY_ONES, 8'd255, -16'sd1, BOUND_SPARE,
			7'd127, 7'd127);
		send_request(tts_pkg::OP_LOOKUP, KEY_ONES, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_PROTECT, KEY_D, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_LOOKUP, KEY_D, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_CLEAR, KEY_ONES, 8'd255, -16'sd1, BOUND_SPARE,
			7'd127, 7'd127);
		send_request(tts_pkg::OP_LOOKUP, KEY_A, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_LOOKUP, '0, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);
		send_request(tts_pkg::OP_PROTECT, '0, 8'd0, 16'sd0, BOUND_EXACT, 7'd0, 7'd0);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			calm <= (n >= 400 && n < 600);
			send_random_request();
		end
		in_valid <= 1'b0;

		// let the checker log the last request before draining
		@(posedge clk);
		while (replies_due != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
